[design/zfbp_pkg.sv]
// Shared types and constants for the zero-flag bit packer.
`timescale 1ns / 1ps
`default_nettype none

package zfbp_pkg;

    localparam int unsigned WORD_W = 64;
    localparam int unsigned BYTE_W = 8;
    // Longest run of pending plus newly added bits: seven held bits, a flag and a word.
    localparam int unsigned ACC_W  = 72;
    localparam int unsigned CNT_W  = 7;

    // One classified word as it travels from the front end to the packer.
    typedef struct packed {
        logic              last;
        logic              nonzero;
        logic [WORD_W-1:0] value;
    } t_item;

endpackage

`default_nettype wire

[design/zfbp_front.sv]
// Front end: accepts words, classifies them as zero or nonzero, and queues them.
`timescale 1ns / 1ps
`default_nettype none

module zfbp_front
    import zfbp_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_s_tvalid,
    output logic                   o_s_tready,
    input  wire logic [WORD_W-1:0] i_s_tdata,
    input  wire logic              i_s_tlast,
    output logic                   o_q_valid,
    output t_item                  o_q_item,
    input  wire logic              i_q_pop
);

    t_item       r_mem [2];
    logic        r_wr_ptr;
    logic        r_rd_ptr;
    logic [1:0]  r_count;
    logic        w_push;
    t_item       w_item;

    assign o_s_tready = (r_count != 2'd2);
    assign w_push     = i_s_tvalid && o_s_tready;
    assign o_q_valid  = (r_count != 2'd0);
    assign o_q_item   = r_mem[r_rd_ptr];

    // Sign bit is ignored so that negative zero counts as zero.
    always_comb begin
        w_item.last    = i_s_tlast;
        w_item.nonzero = |i_s_tdata[WORD_W-2:0];
        w_item.value   = i_s_tdata;
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_q_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + {1'b0, w_push} - {1'b0, i_q_pop};
        end
    end

endmodule

`default_nettype wire

[design/zfbp_back.sv]
// Back end: merges queued words into a bit accumulator and drains it a byte at a time.
`timescale 1ns / 1ps
`default_nettype none

module zfbp_back
    import zfbp_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_q_valid,
    input  wire t_item             i_q_item,
    output logic                   o_q_pop,
    output logic                   o_m_tvalid,
    input  wire logic              i_m_tready,
    output logic [BYTE_W-1:0]      o_m_tdata,
    output logic                   o_m_tlast
);

    // Accumulator is left aligned: the oldest bit sits in the top position and
    // every bit below the count is zero.
    logic [ACC_W-1:0]  r_acc,     n_acc;
    logic [CNT_W-1:0]  r_cnt,     n_cnt;
    logic              r_busy,    n_busy;
    logic              r_last,    n_last;
    logic              r_m_valid, n_m_valid;
    logic [BYTE_W-1:0] r_m_data,  n_m_data;
    logic              r_m_last,  n_m_last;

    logic              w_out_free;
    logic              w_under_byte;
    logic              w_load;
    logic [ACC_W-1:0]  w_new_bits;

    assign w_out_free   = !r_m_valid || i_m_tready;
    assign w_under_byte = (r_cnt[CNT_W-1:3] == '0);
    assign w_load       = i_q_valid && (!r_busy || (w_under_byte && !r_last));
    assign o_q_pop      = w_load;

    // Nonzero word: a one flag then the word; zero word: a single zero flag.
    assign w_new_bits = i_q_item.nonzero ? {1'b1, i_q_item.value, 7'b0} : '0;

    always_comb begin
        n_acc     = r_acc;
        n_cnt     = r_cnt;
        n_busy    = r_busy;
        n_last    = r_last;
        n_m_valid = r_m_valid && !i_m_tready;
        n_m_data  = r_m_data;
        n_m_last  = r_m_last;
        priority if (w_load) begin
            n_acc  = r_acc | (w_new_bits >> r_cnt[2:0]);
            n_cnt  = r_cnt + (i_q_item.nonzero ? CNT_W'(WORD_W + 1) : CNT_W'(1));
            n_last = i_q_item.last;
            n_busy = 1'b1;
        end else if (r_busy && w_out_free && !w_under_byte) begin
            n_m_valid = 1'b1;
            n_m_data  = r_acc[ACC_W-1 -: BYTE_W];
            n_m_last  = 1'b0;
            n_acc     = r_acc << BYTE_W;
            n_cnt     = r_cnt - CNT_W'(BYTE_W);
        end else if (r_busy && w_out_free && r_last) begin
            // Flush: pending bits already sit zero padded in the top byte.
            n_m_valid = 1'b1;
            n_m_data  = r_acc[ACC_W-1 -: BYTE_W];
            n_m_last  = 1'b1;
            n_acc     = '0;
            n_cnt     = '0;
            n_last    = 1'b0;
            n_busy    = 1'b0;
        end else begin
            n_acc = r_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m_data <= n_m_data;
        r_m_last <= n_m_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc     <= '0;
            r_cnt     <= '0;
            r_busy    <= 1'b0;
            r_last    <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_acc     <= n_acc;
            r_cnt     <= n_cnt;
            r_busy    <= n_busy;
            r_last    <= n_last;
            r_m_valid <= n_m_valid;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;
    assign o_m_tlast  = r_m_last;

endmodule

`default_nettype wire

[design/zero_flag_bit_packer.sv]
// Top level of the zero-flag bit packer: front end, queue and byte packer.
`timescale 1ns / 1ps
`default_nettype none

// The block compresses a stream of 64-bit double-precision words into bytes.
// A word whose bits 62 to 0 are all zero (positive or negative zero) adds a
// single 0 bit; any other word adds a 1 bit followed by all 64 bits of the
// word, most significant first. Bits fill the output bytes from the most
// significant end, and each byte leaves as soon as it is complete. The word
// that arrives with tlast set closes the stream: one more byte is always sent,
// holding the leftover bits padded with zeros (or all zeros when none are
// left), and it carries tlast. The packer state then returns to its reset
// value. A front end classifies each word and places it in a two-entry queue,
// so input transactions continue while the packer drains earlier words. The
// output is a single registered byte per clock while tready stays high, and
// that port sets the pace: a nonzero word yields eight or nine bytes, and a
// zero word yields one only when its flag bit completes a byte, plus the
// flush byte on the last word.
// Input tready is high straight after reset.

module zero_flag_bit_packer
    import zfbp_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_s_tvalid,
    output logic                   o_s_tready,
    input  wire logic [WORD_W-1:0] i_s_tdata,   // [63:0] value_bits
    input  wire logic              i_s_tlast,   // last_value
    output logic                   o_m_tvalid,
    input  wire logic              i_m_tready,
    output logic [BYTE_W-1:0]      o_m_tdata,   // [7:0] out_byte
    output logic                   o_m_tlast    // last_byte
);

    logic  w_q_valid;
    t_item w_q_item;
    logic  w_q_pop;

    // Accepts and classifies words, buffering up to two of them.
    zfbp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_q_valid  (w_q_valid),
        .o_q_item   (w_q_item),
        .i_q_pop    (w_q_pop)
    );

    // Packs the bits and presents one byte per transaction.
    zfbp_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (w_q_valid),
        .i_q_item   (w_q_item),
        .o_q_pop    (w_q_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

`default_nettype wire

[design/zfbp_checker.sv]
// Port-level checker for the zero-flag bit packer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module zfbp_checker
    import zfbp_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_s_tvalid,
    input wire logic              o_s_tready,
    input wire logic              i_s_tlast,
    input wire logic              o_m_tvalid,
    input wire logic              i_m_tready,
    input wire logic [BYTE_W-1:0] o_m_tdata,
    input wire logic              o_m_tlast
);

    // Streams opened by a last input word and not yet closed by a last byte.
    logic [3:0] r_open;
    logic       w_in_last;
    logic       w_out_last;

    assign w_in_last  = i_s_tvalid && o_s_tready && i_s_tlast;
    assign w_out_last = o_m_tvalid && i_m_tready && o_m_tlast;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= '0;
        end else begin
            r_open <= r_open + {3'b0, w_in_last} - {3'b0, w_out_last};
        end
    end

    a_idle_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid && o_s_tready)
        else $error("output valid or input stall right after reset");

    a_hold_when_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tlast))
        else $error("stalled output byte changed");

    a_last_needs_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_last |-> r_open != 4'd0)
        else $error("last byte without a last input word");

    a_open_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_open <= 4'd4)
        else $error("too many streams in flight");

endmodule

bind zero_flag_bit_packer zfbp_checker u_zfbp_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tlast  (i_s_tlast),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);

`default_nettype wire

[tb/zero_flag_bit_packer_tb.sv]
// Self-checking testbench for the zero-flag bit packer.
`timescale 1ns / 1ps
`default_nettype none

module zero_flag_bit_packer_tb;
    import zfbp_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned RANDOM_WORDS = 96;
    // Once this few words remain to be sent, neither side starts a new idle burst.
    localparam int unsigned CALM_TAIL = 30;
    localparam int unsigned DRAIN_CYCLES = 24;
    localparam int unsigned REPORT_LIMIT = 10;

    typedef struct packed {
        logic [WORD_W-1:0] value;
        logic              last;
    } t_word_item;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } t_packed_byte;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_s_tvalid = 1'b0;
    logic              o_s_tready;
    logic [WORD_W-1:0] i_s_tdata = '0;   // [63:0] value_bits
    logic              i_s_tlast = 1'b0; // last_value
    logic              o_m_tvalid;
    logic              i_m_tready = 1'b0;
    logic [BYTE_W-1:0] o_m_tdata;        // [7:0] out_byte
    logic              o_m_tlast;        // last_byte

    t_word_item   word_queue[$];
    t_packed_byte expected_bytes[$];
    t_word_item   next_word;

    // Bits still waiting to complete a byte, the oldest one highest.
    logic [6:0] held_bits = '0;
    logic [2:0] held_count = '0;

    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;
    int unsigned in_gap = 0;
    int unsigned out_stall = 0;

    zero_flag_bit_packer u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    always #4 i_clk = ~i_clk;

    // Appends the bytes that one accepted word produces to the expected stream.
    task automatic pack_word(input logic [WORD_W-1:0] value, input logic last);
        logic [WORD_W:0]   bits;
        int                nbits;
        logic [BYTE_W-1:0] acc;
        int                cnt;
        t_packed_byte      pb;
        acc = {1'b0, held_bits};
        cnt = held_count;
        // Positive and negative zero both reduce to a single 0 flag bit.
        if (value[WORD_W-2:0] == '0) begin
            bits = '0;
            nbits = 1;
        end else begin
            bits = {1'b1, value};
            nbits = WORD_W + 1;
        end
        for (int i = nbits - 1; i >= 0; i--) begin
            acc = {acc[BYTE_W-2:0], bits[i]};
            cnt++;
            if (cnt == BYTE_W) begin
                pb.data = acc;
                pb.last = 1'b0;
                expected_bytes.push_back(pb);
                acc = '0;
                cnt = 0;
            end
        end
        // The closing word always adds one byte, all zero when nothing is held.
        if (last) begin
            pb.data = (cnt == 0) ? '0 : BYTE_W'(acc << (BYTE_W - cnt));
            pb.last = 1'b1;
            expected_bytes.push_back(pb);
            acc = '0;
            cnt = 0;
        end
        held_bits = acc[6:0];
        held_count = cnt[2:0];
    endtask

    task automatic add_word(input logic [WORD_W-1:0] value, input logic last);
        t_word_item w;
        w.value = value;
        w.last = last;
        word_queue.push_back(w);
    endtask

    task automatic note_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
            $display("mismatch at %0t: %s", $realtime, what);
        end
    endtask

    // Input driver: takes words from the queue and presents them with random gaps.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                pack_word(i_s_tdata, i_s_tlast);
            end
            if (!i_s_tvalid || o_s_tready) begin
                if (in_gap > 0) begin
                    in_gap = in_gap - 1;
                    i_s_tvalid <= 1'b0;
                end else if (word_queue.size() == 0) begin
                    i_s_tvalid <= 1'b0;
                end else if (word_queue.size() > CALM_TAIL && $urandom_range(0, 7) == 0) begin
                    in_gap = $urandom_range(1, 15) - 1;
                    i_s_tvalid <= 1'b0;
                end else begin
                    next_word = word_queue.pop_front();
                    i_s_tvalid <= 1'b1;
                    i_s_tdata <= next_word.value;
                    i_s_tlast <= next_word.last;
                end
            end
        end
    end

    // Output monitor: checks every byte transaction and stalls the port in bursts.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                if (expected_bytes.size() == 0) begin
                    note_mismatch($sformatf("unexpected byte %02h last %b",
                                            o_m_tdata, o_m_tlast));
                end else begin
                    t_packed_byte exp_byte;
                    exp_byte = expected_bytes.pop_front();
                    if (o_m_tdata !== exp_byte.data) begin
                        note_mismatch($sformatf("out_byte expected %02h actual %02h",
                                                exp_byte.data, o_m_tdata));
                    end
                    if (o_m_tlast !== exp_byte.last) begin
                        note_mismatch($sformatf("last_byte expected %b actual %b",
                                                exp_byte.last, o_m_tlast));
                    end
                end
            end
            if (out_stall > 0) begin
                out_stall = out_stall - 1;
                i_m_tready <= 1'b0;
            end else if (word_queue.size() > CALM_TAIL && $urandom_range(0, 5) == 0) begin
                out_stall = $urandom_range(1, 15) - 1;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** zero_flag_bit_packer: FAILED **");
            $finish;
        end
    end

    initial begin
        logic [WORD_W-1:0] value;
        int                kind;
        // Seven zero words (one of them negative) leave seven bits held, so the
        // nonzero closing word yields nine full bytes and the flush byte.
        for (int i = 0; i < 7; i++) begin
            add_word((i == 3) ? 64'h8000_0000_0000_0000 : '0, 1'b0);
        end
        add_word('1, 1'b1);
        // Eight zero bits complete a byte, so the flush finds nothing held.
        for (int i = 0; i < 7; i++) begin
            add_word('0, 1'b0);
        end
        add_word(64'h8000_0000_0000_0000, 1'b1);
        // A lone negative zero closing the stream.
        add_word(64'h8000_0000_0000_0000, 1'b1);
        // Smallest and odd nonzero patterns, infinity and a NaN.
        add_word(64'h0000_0000_0000_0001, 1'b0);
        add_word(64'h8000_0000_0000_0001, 1'b0);
        add_word(64'h7FF0_0000_0000_0000, 1'b0);
        add_word(64'hFFF8_0000_0000_0001, 1'b0);
        add_word(64'h4000_0000_0000_0000, 1'b0);
        add_word(64'h5555_5555_AAAA_AAAA, 1'b1);
        add_word(64'h3FF0_0000_0000_0000, 1'b1);

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            kind = $urandom_range(0, 9);
            if (kind < 3) begin
                value = {1'($urandom_range(0, 1)), 63'b0};
            end else if (kind == 3) begin
                value = 64'h1 << $urandom_range(0, 63);
                if ($urandom_range(0, 3) == 0) begin
                    value = ~value;
                end
            end else begin
                value = {$urandom, $urandom};
            end
            add_word(value, (n == RANDOM_WORDS - 1) || ($urandom_range(0, 9) == 0));
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        while (word_queue.size() != 0 || i_s_tvalid || expected_bytes.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_bytes.size() != 0) begin
            note_mismatch($sformatf("%0d expected bytes never arrived", expected_bytes.size()));
        end
        if (mismatch_count == 0) begin
            $display("** zero_flag_bit_packer: PASSED **");
        end else begin
            $display("** zero_flag_bit_packer: FAILED **");
        end
        $finish;
    end

endmodule

`default_nettype wire

[filelist.f]
design/zfbp_pkg.sv
design/zfbp_front.sv
design/zfbp_back.sv
design/zero_flag_bit_packer.sv
design/zfbp_checker.sv
tb/zero_flag_bit_packer_tb.sv
